>>> sv/asfc_pkg.sv
// Shared codes, constants and helper functions for the audio sample format converter.
package asfc_pkg;

    // Sample format codes
    localparam logic [2:0] FMT_PCM8  = 3'd0;
    localparam logic [2:0] FMT_PCM16 = 3'd1;
    localparam logic [2:0] FMT_PCM24 = 3'd2;
    localparam logic [2:0] FMT_PCM32 = 3'd3;
    localparam logic [2:0] FMT_F32   = 3'd4;
    localparam logic [2:0] FMT_F64   = 3'd5;

    // Configuration register indexes
    localparam logic [0:0] REG_SOURCE_FORMAT = 1'b0;
    localparam logic [0:0] REG_TARGET_FORMAT = 1'b1;

    // Datapath selection carried down the pipeline
    localparam logic [1:0] PATH_PASS     = 2'd0;
    localparam logic [1:0] PATH_TO_FLOAT = 2'd1;
    localparam logic [1:0] PATH_TO_INT   = 2'd2;

    // Output scale factors, left-aligned so bit 30 is set
    localparam logic [30:0] K_PCM16 = 31'h7FFF0000;  // 32767 << 16
    localparam logic [30:0] K_F32   = 31'h7FFFFF80;  // 2147483520
    localparam logic [30:0] K_F64   = 31'h7FFFFFFF;  // 2147483647

    typedef logic signed [12:0] t_exp;

    // Count leading zeros of a 32-bit word; 32 for zero
    function automatic logic [5:0] lzc32(input logic [31:0] w);
        logic [5:0] n;
        n = 6'd32;
        for (int i = 0; i < 32; i++) begin
            if (w[i]) n = 6'(31 - i);
        end
        return n;
    endfunction

    // Mask of the valid low bits for a format
    function automatic logic [63:0] width_mask(input logic [2:0] fmt);
        logic [63:0] m;
        unique case (fmt)
            FMT_PCM8:  m = 64'h0000_0000_0000_00FF;
            FMT_PCM16: m = 64'h0000_0000_0000_FFFF;
            FMT_PCM24: m = 64'h0000_0000_00FF_FFFF;
            FMT_PCM32: m = 64'h0000_0000_FFFF_FFFF;
            FMT_F32:   m = 64'h0000_0000_FFFF_FFFF;
            default:   m = 64'hFFFF_FFFF_FFFF_FFFF;
        endcase
        return m;
    endfunction

    // Left-align a PCM sample to 32 bits
    function automatic logic [31:0] align32(input logic [63:0] b, input logic [2:0] fmt);
        logic [31:0] u;
        unique case (fmt)
            FMT_PCM8:  u = {b[7:0], 24'b0};
            FMT_PCM16: u = {b[15:0], 16'b0};
            FMT_PCM24: u = {b[23:0], 8'b0};
            default:   u = b[31:0];
        endcase
        return u;
    endfunction

    // Take the top bits of a left-aligned 32-bit value for the target width
    function automatic logic [63:0] pcm_result(input logic [31:0] u, input logic [2:0] fmt);
        logic [63:0] r;
        unique case (fmt)
            FMT_PCM16: r = {48'b0, u[31:16]};
            FMT_PCM24: r = {40'b0, u[31:8]};
            default:   r = {32'b0, u};
        endcase
        return r;
    endfunction

endpackage

>>> sv/audio_sample_format_converter.sv
// Audio sample format converter: PCM8/16/24/32, float32 and float64, one sample per clock.
//
//  channel   | handshake              | payload
//  ----------+------------------------+-------------------------------------------
//  input     | start, busy            | i_sample_bits, i_end_of_chunk
//  result    | o_result_valid         | o_result_bits, o_clipped, o_chunk_end
//  config    | i_cfg_we, i_cfg_index  | i_cfg_wdata
//
// One item per clock; each result passes stage registers r1 to r5 and then the output register.
// The depth is set by the float-to-integer path: split 53x31 multiply,
// partial product sum, rounding add, alignment shift and saturation.
// busy is always low; the receiver takes every result in the cycle it is shown.
// Synchronous active-low reset clears the stage valid bits and sets both formats to pcm16.
module audio_sample_format_converter (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [63:0] i_sample_bits,
    input  logic        i_end_of_chunk,
    output logic        o_result_valid,
    output logic [63:0] o_result_bits,
    output logic        o_clipped,
    output logic        o_chunk_end,
    input  logic        i_cfg_we,
    input  logic [0:0]  i_cfg_index,
    input  logic [2:0]  i_cfg_wdata
);

    // Configuration
    logic [2:0] r_src_fmt;
    logic [2:0] r_tgt_fmt;

    // Stage 0 decode
    logic        s0_src_ok, s0_tgt_ok, s0_src_int, s0_tgt_int;
    logic [31:0] s0_u32;
    logic        f32_s, f64_s;
    logic [7:0]  f32_e;
    logic [22:0] f32_f;
    logic [10:0] f64_e;
    logic [51:0] f64_f;

    logic [1:0]          n1_path;
    logic [63:0]         n1_res;
    logic                n1_clip;
    logic                n1_sign;
    logic                n1_nrm;
    logic [31:0]         n1_word;
    asfc_pkg::t_exp      n1_exp;
    logic [63:0]         n1_mant;
    logic [52:0]         n1_m53;
    logic [30:0]         n1_k;
    logic                n1_p24;

    // Stage 1 registers
    logic                r1_v, r1_chunk, r1_clip, r1_sign, r1_nrm, r1_p24;
    logic [1:0]          r1_path;
    logic [2:0]          r1_tgt;
    logic [63:0]         r1_res, r1_mant;
    logic [31:0]         r1_word;
    asfc_pkg::t_exp      r1_exp;
    logic [52:0]         r1_m53;
    logic [30:0]         r1_k;

    // Stage 2 logic and registers
    logic [5:0]          s2_lz;
    logic [31:0]         s2_norm;
    logic [57:0]         s2_pp_lo;
    logic [56:0]         s2_pp_hi;
    logic                r2_v, r2_chunk, r2_clip, r2_sign, r2_p24;
    logic [1:0]          r2_path;
    logic [2:0]          r2_tgt;
    logic [63:0]         r2_res, r2_mant;
    asfc_pkg::t_exp      r2_exp;
    logic [57:0]         r2_pp_lo;
    logic [56:0]         r2_pp_hi;

    // Stage 3 logic and registers
    logic                s3_sub, s3_lost, s3_ovf;
    asfc_pkg::t_exp      s3_dw, s3_eb32, s3_eb64;
    logic [6:0]          s3_d;
    logic [63:0]         s3_shr;
    logic [7:0]          s3_e8;
    logic                r3_v, r3_chunk, r3_clip, r3_sign, r3_p24, r3_rb, r3_st, r3_ovf;
    logic [1:0]          r3_path;
    logic [2:0]          r3_tgt;
    logic [63:0]         r3_res;
    logic [30:0]         r3_base;
    logic [83:0]         r3_q;
    asfc_pkg::t_exp      r3_exp;

    // Stage 4 logic and registers
    logic                s4_fru;
    logic [31:0]         s4_f32;
    logic [83:0]         s4_qn;
    logic                s4_lsb, s4_rb, s4_st, s4_ru;
    logic [84:0]         s4_kept, s4_inc;
    logic                r4_v, r4_chunk, r4_clip, r4_sign;
    logic [1:0]          r4_path;
    logic [2:0]          r4_tgt;
    logic [63:0]         r4_res;
    logic [84:0]         r4_rq;
    asfc_pkg::t_exp      r4_exp;

    // Stage 5 logic and registers
    logic                s5_big;
    asfc_pkg::t_exp      s5_sh;
    logic [34:0]         s5_t;
    logic                r5_v, r5_chunk, r5_clip, r5_sign, r5_big;
    logic [1:0]          r5_path;
    logic [2:0]          r5_tgt;
    logic [63:0]         r5_res;
    logic [34:0]         r5_t;

    // Output stage
    logic [34:0]         s6_lim;
    logic                s6_over, s6_clip;
    logic [31:0]         s6_mag, s6_v;
    logic [63:0]         n_o_res;
    logic                n_o_clip;
    logic                r_o_valid, r_o_clip, r_o_chunk;
    logic [63:0]         r_o_res;

    assign busy           = 1'b0;
    assign o_result_valid = r_o_valid;
    assign o_result_bits  = r_o_res;
    assign o_clipped      = r_o_clip;
    assign o_chunk_end    = r_o_chunk;

    // Split the raw sample into float fields
    assign f32_s = i_sample_bits[31];
    assign f32_e = i_sample_bits[30:23];
    assign f32_f = i_sample_bits[22:0];
    assign f64_s = i_sample_bits[63];
    assign f64_e = i_sample_bits[62:52];
    assign f64_f = i_sample_bits[51:0];

    assign s0_src_ok  = (r_src_fmt <= asfc_pkg::FMT_F64);
    assign s0_tgt_ok  = (r_tgt_fmt != asfc_pkg::FMT_PCM8) && (r_tgt_fmt <= asfc_pkg::FMT_F64);
    assign s0_src_int = (r_src_fmt <= asfc_pkg::FMT_PCM32);
    assign s0_tgt_int = (r_tgt_fmt <= asfc_pkg::FMT_PCM32);
    assign s0_u32     = asfc_pkg::align32(i_sample_bits, r_src_fmt);

    // Decode the item: settle trivial and special cases, unpack the rest
    always_comb begin
        n1_path = asfc_pkg::PATH_PASS;
        n1_res  = '0;
        n1_clip = 1'b0;
        n1_sign = 1'b0;
        n1_nrm  = 1'b0;
        n1_word = '0;
        n1_exp  = '0;
        n1_mant = '0;
        n1_m53  = '0;
        n1_k    = asfc_pkg::K_F64;
        n1_p24  = 1'b0;
        if (!s0_src_ok || !s0_tgt_ok) begin
            n1_res = '0;
        end else if (r_src_fmt == r_tgt_fmt) begin
            n1_res = i_sample_bits & asfc_pkg::width_mask(r_src_fmt);
        end else if (s0_src_int) begin
            if (s0_tgt_int) begin
                n1_res = asfc_pkg::pcm_result(s0_u32, r_tgt_fmt);
            end else if (s0_u32 == 32'd0) begin
                n1_res = '0;
            end else begin
                n1_path = asfc_pkg::PATH_TO_FLOAT;
                n1_sign = s0_u32[31];
                n1_word = s0_u32[31] ? (32'd0 - s0_u32) : s0_u32;
                n1_nrm  = 1'b1;
                n1_exp  = '0;
            end
        end else if (r_src_fmt == asfc_pkg::FMT_F32) begin
            if (r_tgt_fmt == asfc_pkg::FMT_F64) begin
                if (f32_e == 8'hFF && f32_f != 23'd0) begin
                    n1_res = {f32_s, 11'h7FF, 1'b1, f32_f[21:0], 29'b0};
                end else if (f32_e == 8'hFF) begin
                    n1_res = {f32_s, 11'h7FF, 52'b0};
                end else if (f32_e == 8'd0 && f32_f == 23'd0) begin
                    n1_res = {f32_s, 63'b0};
                end else begin
                    n1_path = asfc_pkg::PATH_TO_FLOAT;
                    n1_sign = f32_s;
                    if (f32_e == 8'd0) begin
                        n1_nrm  = 1'b1;
                        n1_word = {f32_f, 9'b0};
                        n1_exp  = -13'sd127;
                    end else begin
                        n1_mant = {1'b1, f32_f, 40'b0};
                        n1_exp  = asfc_pkg::t_exp'({5'b0, f32_e}) - 13'sd127;
                    end
                end
            end else begin
                if (f32_e == 8'hFF && f32_f != 23'd0) begin
                    n1_clip = 1'b1;
                end else if (f32_e == 8'hFF) begin
                    n1_clip = 1'b1;
                    unique case (r_tgt_fmt)
                        asfc_pkg::FMT_PCM16: n1_res = f32_s ? 64'h8000 : 64'h7FFF;
                        asfc_pkg::FMT_PCM24: n1_res = f32_s ? 64'h80_0000 : 64'h7F_FFFF;
                        default:             n1_res = f32_s ? 64'h8000_0000 : 64'h7FFF_FFFF;
                    endcase
                end else if (f32_e != 8'd0) begin
                    n1_path = asfc_pkg::PATH_TO_INT;
                    n1_sign = f32_s;
                    n1_p24  = 1'b1;
                    n1_m53  = {1'b1, f32_f, 29'b0};
                    if (r_tgt_fmt == asfc_pkg::FMT_PCM16) begin
                        n1_k   = asfc_pkg::K_PCM16;
                        n1_exp = asfc_pkg::t_exp'({5'b0, f32_e}) - 13'sd127 - 13'sd68;
                    end else begin
                        n1_k   = asfc_pkg::K_F32;
                        n1_exp = asfc_pkg::t_exp'({5'b0, f32_e}) - 13'sd127 - 13'sd52;
                    end
                end
            end
        end else begin
            if (r_tgt_fmt == asfc_pkg::FMT_F32) begin
                if (f64_e == 11'h7FF && f64_f != 52'd0) begin
                    n1_res = {32'b0, f64_s, 8'hFF, 1'b1, f64_f[50:29]};
                end else if (f64_e == 11'h7FF) begin
                    n1_res = {32'b0, f64_s, 8'hFF, 23'b0};
                end else if (f64_e == 11'd0) begin
                    // zero and subnormals lie far below the float32 range
                    n1_res = {32'b0, f64_s, 31'b0};
                end else begin
                    n1_path = asfc_pkg::PATH_TO_FLOAT;
                    n1_sign = f64_s;
                    n1_mant = {1'b1, f64_f, 11'b0};
                    n1_exp  = asfc_pkg::t_exp'({2'b0, f64_e}) - 13'sd1023;
                end
            end else begin
                if (f64_e == 11'h7FF && f64_f != 52'd0) begin
                    n1_clip = 1'b1;
                end else if (f64_e == 11'h7FF) begin
                    n1_clip = 1'b1;
                    unique case (r_tgt_fmt)
                        asfc_pkg::FMT_PCM16: n1_res = f64_s ? 64'h8000 : 64'h7FFF;
                        asfc_pkg::FMT_PCM24: n1_res = f64_s ? 64'h80_0000 : 64'h7F_FFFF;
                        default:             n1_res = f64_s ? 64'h8000_0000 : 64'h7FFF_FFFF;
                    endcase
                end else if (f64_e != 11'd0) begin
                    n1_path = asfc_pkg::PATH_TO_INT;
                    n1_sign = f64_s;
                    n1_m53  = {1'b1, f64_f};
                    if (r_tgt_fmt == asfc_pkg::FMT_PCM16) begin
                        n1_k   = asfc_pkg::K_PCM16;
                        n1_exp = asfc_pkg::t_exp'({2'b0, f64_e}) - 13'sd1023 - 13'sd68;
                    end else begin
                        n1_k   = asfc_pkg::K_F64;
                        n1_exp = asfc_pkg::t_exp'({2'b0, f64_e}) - 13'sd1023 - 13'sd52;
                    end
                end
            end
        end
    end

    // Stage 2: normalize integers and float32 subnormals, form partial products
    assign s2_lz    = asfc_pkg::lzc32(r1_word);
    assign s2_norm  = r1_word << s2_lz;
    assign s2_pp_lo = r1_m53[26:0] * r1_k;
    assign s2_pp_hi = r1_m53[52:27] * r1_k;

    // Stage 3: align for float32 subnormal output, build float64 result, sum the partial products
    assign s3_sub  = (r2_exp < -13'sd126);
    assign s3_dw   = -13'sd126 - r2_exp;
    assign s3_d    = !s3_sub ? 7'd0 : ((s3_dw > 13'sd63) ? 7'd64 : s3_dw[6:0]);
    assign s3_shr  = r2_mant >> s3_d;
    assign s3_lost = ((s3_shr << s3_d) != r2_mant);
    assign s3_eb32 = r2_exp + 13'sd127;
    assign s3_eb64 = r2_exp + 13'sd1023;
    assign s3_ovf  = !s3_sub && (s3_eb32 > 13'sd254);
    assign s3_e8   = s3_sub ? 8'd0 : s3_eb32[7:0];

    // Stage 4: round float32 result; normalize and round the integer product
    assign s4_fru  = r3_rb & (r3_st | r3_base[0]);
    assign s4_f32  = r3_ovf ? {r3_sign, 8'hFF, 23'b0} : {r3_sign, r3_base + 31'(s4_fru)};
    assign s4_qn   = r3_q[83] ? r3_q : {r3_q[82:0], 1'b0};
    assign s4_lsb  = r3_p24 ? s4_qn[60] : s4_qn[31];
    assign s4_rb   = r3_p24 ? s4_qn[59] : s4_qn[30];
    assign s4_st   = r3_p24 ? (|s4_qn[58:0]) : (|s4_qn[29:0]);
    assign s4_ru   = s4_rb & (s4_st | s4_lsb);
    assign s4_kept = r3_p24 ? {1'b0, s4_qn[83:60], 60'b0} : {1'b0, s4_qn[83:31], 31'b0};
    assign s4_inc  = r3_p24 ? (85'd1 << 60) : (85'd1 << 31);

    // Stage 5: truncate the rounded product toward zero
    assign s5_big = (r4_exp >= -13'sd50);
    assign s5_sh  = -r4_exp;
    always_comb begin
        if (s5_big) begin
            s5_t = '1;
        end else if (s5_sh > 13'sd84) begin
            s5_t = '0;
        end else begin
            s5_t = 35'(r4_rq >> s5_sh[6:0]);
        end
    end

    // Output stage: saturate and format integer results
    assign s6_lim  = (r5_tgt == asfc_pkg::FMT_PCM16) ? 35'h0_0000_8000 : 35'h0_8000_0000;
    assign s6_over = r5_big || (r5_t >= s6_lim);
    assign s6_clip = r5_sign ? (r5_big || (r5_t > s6_lim)) : s6_over;
    always_comb begin
        if (s6_over) begin
            s6_mag = r5_sign ? s6_lim[31:0] : (s6_lim[31:0] - 32'd1);
        end else begin
            s6_mag = r5_t[31:0];
        end
    end
    assign s6_v = r5_sign ? (32'd0 - s6_mag) : s6_mag;

    always_comb begin
        if (r5_path == asfc_pkg::PATH_TO_INT) begin
            n_o_clip = s6_clip;
            if (r5_tgt == asfc_pkg::FMT_PCM16) begin
                n_o_res = {48'b0, s6_v[15:0]};
            end else begin
                n_o_res = asfc_pkg::pcm_result(s6_v, r5_tgt);
            end
        end else begin
            n_o_clip = r5_clip;
            n_o_res  = r5_res;
        end
    end

    // Control: configuration and stage valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_fmt <= asfc_pkg::FMT_PCM16;
            r_tgt_fmt <= asfc_pkg::FMT_PCM16;
            r1_v      <= 1'b0;
            r2_v      <= 1'b0;
            r3_v      <= 1'b0;
            r4_v      <= 1'b0;
            r5_v      <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    asfc_pkg::REG_SOURCE_FORMAT: r_src_fmt <= i_cfg_wdata;
                    asfc_pkg::REG_TARGET_FORMAT: r_tgt_fmt <= i_cfg_wdata;
                endcase
            end
            r1_v      <= start && !busy;
            r2_v      <= r1_v;
            r3_v      <= r2_v;
            r4_v      <= r3_v;
            r5_v      <= r4_v;
            r_o_valid <= r5_v;
        end
    end

    // Datapath: advance the payload one stage per clock
    always_ff @(posedge i_clk) begin
        r1_chunk <= i_end_of_chunk;
        r1_path  <= n1_path;
        r1_tgt   <= r_tgt_fmt;
        r1_res   <= n1_res;
        r1_clip  <= n1_clip;
        r1_sign  <= n1_sign;
        r1_nrm   <= n1_nrm;
        r1_word  <= n1_word;
        r1_exp   <= n1_exp;
        r1_mant  <= n1_mant;
        r1_m53   <= n1_m53;
        r1_k     <= n1_k;
        r1_p24   <= n1_p24;

        r2_chunk <= r1_chunk;
        r2_path  <= r1_path;
        r2_tgt   <= r1_tgt;
        r2_res   <= r1_res;
        r2_clip  <= r1_clip;
        r2_sign  <= r1_sign;
        r2_p24   <= r1_p24;
        r2_mant  <= r1_nrm ? {s2_norm, 32'b0} : r1_mant;
        r2_exp   <= r1_nrm ? (r1_exp - asfc_pkg::t_exp'({7'b0, s2_lz})) : r1_exp;
        r2_pp_lo <= s2_pp_lo;
        r2_pp_hi <= s2_pp_hi;

        r3_chunk <= r2_chunk;
        r3_path  <= r2_path;
        r3_tgt   <= r2_tgt;
        r3_clip  <= r2_clip;
        r3_sign  <= r2_sign;
        r3_p24   <= r2_p24;
        r3_exp   <= r2_exp;
        if (r2_path == asfc_pkg::PATH_TO_FLOAT && r2_tgt == asfc_pkg::FMT_F64) begin
            r3_res <= {r2_sign, s3_eb64[10:0], r2_mant[62:11]};
        end else begin
            r3_res <= r2_res;
        end
        r3_base  <= {s3_e8, s3_shr[62:40]};
        r3_rb    <= s3_shr[39];
        r3_st    <= (|s3_shr[38:0]) | s3_lost;
        r3_ovf   <= s3_ovf;
        r3_q     <= {r2_pp_hi, 27'b0} + {26'b0, r2_pp_lo};

        r4_chunk <= r3_chunk;
        r4_path  <= r3_path;
        r4_tgt   <= r3_tgt;
        r4_clip  <= r3_clip;
        r4_sign  <= r3_sign;
        if (r3_path == asfc_pkg::PATH_TO_FLOAT && r3_tgt == asfc_pkg::FMT_F32) begin
            r4_res <= {32'b0, s4_f32};
        end else begin
            r4_res <= r3_res;
        end
        r4_rq    <= s4_kept + (s4_ru ? s4_inc : 85'd0);
        r4_exp   <= r3_q[83] ? r3_exp : (r3_exp - 13'sd1);

        r5_chunk <= r4_chunk;
        r5_path  <= r4_path;
        r5_tgt   <= r4_tgt;
        r5_res   <= r4_res;
        r5_clip  <= r4_clip;
        r5_sign  <= r4_sign;
        r5_t     <= s5_t;
        r5_big   <= s5_big;

        r_o_res   <= n_o_res;
        r_o_clip  <= n_o_clip;
        r_o_chunk <= r5_chunk;
    end

endmodule

>>> dv/tb_top.sv
// Testbench for the audio sample format converter: random and corner samples, self-checking.
`timescale 1ns / 100ps

module tb_top;

    // Codes outside the supported set
    localparam logic [2:0] FMT_CODE_6 = 3'd6;
    localparam logic [2:0] FMT_CODE_7 = 3'd7;

    // Float-to-integer scale factors
    localparam logic [30:0] SCALE_PCM16    = 31'd32767;
    localparam logic [30:0] SCALE_F32_WIDE = 31'd2147483520;
    localparam logic [30:0] SCALE_F64_WIDE = 31'd2147483647;

    localparam int ITEM_TARGET    = 1800;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 12;

    typedef struct {
        logic [63:0] bits;
        logic        clip;
        logic        chunk_end;
    } t_sample_out;

    // Holds the format registers and the queue of converted samples still due
    class format_scoreboard;
        logic [2:0]  src_fmt;
        logic [2:0]  tgt_fmt;
        t_sample_out due[$];
        int          errors;
        int          checked;
        int          clipped;

        function new();
            src_fmt = asfc_pkg::FMT_PCM16;
            tgt_fmt = asfc_pkg::FMT_PCM16;
            errors  = 0;
            checked = 0;
            clipped = 0;
        endfunction

        function void set_format(input logic [0:0] idx, input logic [2:0] val);
            if (idx == asfc_pkg::REG_SOURCE_FORMAT) src_fmt = val;
            else tgt_fmt = val;
        endfunction

        function void report(input string msg);
            errors++;
            $display("MISMATCH @%0t: %s", $realtime, msg);
        endfunction

        function logic [63:0] fmt_mask(input logic [2:0] fmt);
            case (fmt)
                asfc_pkg::FMT_PCM8:  return 64'hFF;
                asfc_pkg::FMT_PCM16: return 64'hFFFF;
                asfc_pkg::FMT_PCM24: return 64'hFF_FFFF;
                asfc_pkg::FMT_PCM32: return 64'hFFFF_FFFF;
                asfc_pkg::FMT_F32:   return 64'hFFFF_FFFF;
                default:             return '1;
            endcase
        endfunction

        // Narrow a double to single precision, round to nearest even
        function logic [31:0] narrow_float(input logic [63:0] b);
            logic        s;
            logic [63:0] sig, rem, half, t;
            int          ef, sh;
            s = b[63];
            if (b[62:52] == 11'h7FF) begin
                if (b[51:0] != 0) return {s, 8'hFF, 1'b1, b[50:29]};
                return {s, 8'hFF, 23'b0};
            end
            if (b[62:52] == 0) return {s, 31'b0};
            sig = {11'b0, 1'b1, b[51:0]};
            ef  = int'(b[62:52]) - 1023 + 127;
            if (ef >= 255) return {s, 8'hFF, 23'b0};
            sh = (ef >= 1) ? 29 : 30 - ef;
            if (sh > 60) return {s, 31'b0};
            t    = sig >> sh;
            rem  = sig & ((64'd1 << sh) - 1);
            half = 64'd1 << (sh - 1);
            if (rem > half || (rem == half && t[0])) t++;
            if (ef < 1) return {s, t[30:0]};
            if (t == 64'h100_0000) begin
                t  = t >> 1;
                ef++;
            end
            if (ef >= 255) return {s, 8'hFF, 23'b0};
            return {s, 8'(ef), t[22:0]};
        endfunction

        // Widen a single to double precision; quiet any NaN
        function logic [63:0] widen_float(input logic [31:0] b);
            logic        s;
            logic [22:0] m;
            logic [51:0] frac;
            int          p;
            s = b[31];
            m = b[22:0];
            p = 0;
            if (b[30:23] == 8'hFF) begin
                if (m != 0) return {s, 11'h7FF, 1'b1, m[21:0], 29'b0};
                return {s, 11'h7FF, 52'b0};
            end
            if (b[30:23] == 0) begin
                if (m == 0) return {s, 63'b0};
                for (int i = 0; i < 23; i++) if (m[i]) p = i;
                frac = 52'(m) << (52 - p);
                return {s, 11'(p - 149 + 1023), frac};
            end
            return {s, 11'(int'(b[30:23]) - 127 + 1023), m, 29'b0};
        endfunction

        // Multiply sig*2^ex by k, round to prec bits, truncate toward zero, saturate
        function void scale_to_int(input logic neg, input logic [63:0] sig, input int ex,
                                   input logic [30:0] k, input int prec, input bit to16,
                                   output longint val, output logic clip);
            logic [127:0] prod, s, rem, half, mag, lim;
            int           n, sh, e2;
            bit           huge;
            prod = 128'(sig) * 128'(k);
            val  = 0;
            clip = 0;
            if (prod == 0) return;
            n = 0;
            for (int i = 0; i < 128; i++) if (prod[i]) n = i;
            s  = prod;
            sh = 0;
            if (n + 1 > prec) begin
                sh   = n + 1 - prec;
                s    = prod >> sh;
                rem  = prod & ((128'd1 << sh) - 1);
                half = 128'd1 << (sh - 1);
                if (rem > half || (rem == half && s[0])) s++;
                if (s == (128'd1 << prec)) begin
                    s = s >> 1;
                    sh++;
                end
            end
            e2   = ex + sh;
            huge = 0;
            mag  = 0;
            if (e2 >= 0) begin
                if (e2 > 60) huge = 1;
                else mag = s << e2;
            end else if (-e2 < 120) begin
                mag = s >> (-e2);
            end
            lim = to16 ? 128'd32768 : 128'd2147483648;
            if (!neg) begin
                if (huge || mag >= lim) begin
                    clip = 1;
                    val  = longint'(lim) - 1;
                end else val = longint'(mag);
            end else begin
                if (huge || mag >= lim + 1) begin
                    clip = 1;
                    val  = -longint'(lim);
                end else val = -longint'(mag);
            end
        endfunction

        // Pack an integer result into the target width
        function logic [63:0] pack_int(input logic [31:0] u, input logic [2:0] tgt);
            if (tgt == asfc_pkg::FMT_PCM16) return {48'b0, u[31:16]};
            if (tgt == asfc_pkg::FMT_PCM24) return {40'b0, u[31:8]};
            return {32'b0, u};
        endfunction

        function t_sample_out convert(input logic [63:0] bits, input logic eoc);
            t_sample_out r;
            logic [31:0] u, fb;
            logic [63:0] w;
            logic [63:0] sig;
            int          ex;
            longint      v;
            logic        clip;
            bit          to16, nan, inf, zero, neg;
            logic [30:0] k;
            r.bits      = 0;
            r.clip      = 0;
            r.chunk_end = eoc;
            if (src_fmt > asfc_pkg::FMT_F64 || tgt_fmt == asfc_pkg::FMT_PCM8
                    || tgt_fmt > asfc_pkg::FMT_F64) return r;
            if (src_fmt == tgt_fmt) begin
                r.bits = bits & fmt_mask(src_fmt);
                return r;
            end
            if (src_fmt <= asfc_pkg::FMT_PCM32) begin
                case (src_fmt)
                    asfc_pkg::FMT_PCM8:  u = {bits[7:0], 24'b0};
                    asfc_pkg::FMT_PCM16: u = {bits[15:0], 16'b0};
                    asfc_pkg::FMT_PCM24: u = {bits[23:0], 8'b0};
                    default:             u = bits[31:0];
                endcase
                if (tgt_fmt <= asfc_pkg::FMT_PCM32) begin
                    r.bits = pack_int(u, tgt_fmt);
                end else begin
                    w = $realtobits(real'(int'(signed'(u))) / 2147483648.0);
                    r.bits = (tgt_fmt == asfc_pkg::FMT_F32) ? {32'b0, narrow_float(w)} : w;
                end
                return r;
            end
            if (src_fmt == asfc_pkg::FMT_F32 && tgt_fmt == asfc_pkg::FMT_F64) begin
                r.bits = widen_float(bits[31:0]);
                return r;
            end
            if (src_fmt == asfc_pkg::FMT_F64 && tgt_fmt == asfc_pkg::FMT_F32) begin
                r.bits = {32'b0, narrow_float(bits)};
                return r;
            end
            // Float source to integer target
            to16 = (tgt_fmt == asfc_pkg::FMT_PCM16);
            if (src_fmt == asfc_pkg::FMT_F32) begin
                fb   = bits[31:0];
                neg  = fb[31];
                nan  = (fb[30:23] == 8'hFF) && (fb[22:0] != 0);
                inf  = (fb[30:23] == 8'hFF) && (fb[22:0] == 0);
                zero = (fb[30:23] == 0);
                sig  = {40'b0, 1'b1, fb[22:0]};
                ex   = int'(fb[30:23]) - 150;
                k    = to16 ? SCALE_PCM16 : SCALE_F32_WIDE;
                scale_to_int(neg, sig, ex, k, 24, to16, v, clip);
            end else begin
                neg  = bits[63];
                nan  = (bits[62:52] == 11'h7FF) && (bits[51:0] != 0);
                inf  = (bits[62:52] == 11'h7FF) && (bits[51:0] == 0);
                zero = (bits[62:52] == 0);
                sig  = {11'b0, 1'b1, bits[51:0]};
                ex   = int'(bits[62:52]) - 1075;
                k    = to16 ? SCALE_PCM16 : SCALE_F64_WIDE;
                scale_to_int(neg, sig, ex, k, 53, to16, v, clip);
            end
            if (nan) begin
                v    = 0;
                clip = 1;
            end else if (inf) begin
                clip = 1;
                v    = to16 ? (neg ? -64'sd32768 : 64'sd32767)
                            : (neg ? -64'sd2147483648 : 64'sd2147483647);
            end else if (zero) begin
                v    = 0;
                clip = 0;
            end
            r.clip = clip;
            if (to16) r.bits = {48'b0, 16'(v)};
            else r.bits = pack_int(32'(v), tgt_fmt);
            return r;
        endfunction

        function void note_sample(input logic [63:0] bits, input logic eoc);
            due.push_back(convert(bits, eoc));
        endfunction

        function void check_result(input logic [63:0] bits, input logic clip, input logic eoc);
            t_sample_out e;
            if (due.size() == 0) begin
                report($sformatf("unexpected result %h", bits));
                return;
            end
            e = due.pop_front();
            checked++;
            if (e.clip) clipped++;
            if (bits !== e.bits)
                report($sformatf("result_bits %h, want %h (fmt %0d->%0d)",
                                 bits, e.bits, src_fmt, tgt_fmt));
            if (clip !== e.clip)
                report($sformatf("clipped %b, want %b for %h", clip, e.clip, e.bits));
            if (eoc !== e.chunk_end)
                report($sformatf("chunk_end %b, want %b", eoc, e.chunk_end));
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [63:0] i_sample_bits = '0;
    logic        i_end_of_chunk = 1'b0;
    logic        o_result_valid;
    logic [63:0] o_result_bits;
    logic        o_clipped;
    logic        o_chunk_end;
    logic        i_cfg_we = 1'b0;
    logic [0:0]  i_cfg_index = '0;
    logic [2:0]  i_cfg_wdata = '0;

    format_scoreboard sb = new();
    int  items_sent = 0;
    int  phases = 0;
    int  idle_cycles = 0;
    bit  no_gaps = 0;

    audio_sample_format_converter u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_sample_bits  (i_sample_bits),
        .i_end_of_chunk (i_end_of_chunk),
        .o_result_valid (o_result_valid),
        .o_result_bits  (o_result_bits),
        .o_clipped      (o_clipped),
        .o_chunk_end    (o_chunk_end),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_wdata    (i_cfg_wdata)
    );

    always #2 i_clk = ~i_clk;

    // Check every shown result
    always @(posedge i_clk) begin
        if (i_rst_n && o_result_valid) sb.check_result(o_result_bits, o_clipped, o_chunk_end);
    end

    // Abort when nothing moves for too long
    always @(posedge i_clk) begin
        if ((start && !busy) || o_result_valid || i_cfg_we || !i_rst_n) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no progress for %0d cycles", WATCHDOG_LIMIT);
            $display("DONE: errors detected");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Write one format register while the block is idle
    task automatic write_reg(input logic [0:0] idx, input logic [2:0] val);
        @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_index = idx;
        i_cfg_wdata = val;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        sb.set_format(idx, val);
    endtask

    // Offer one item after a random gap (none when no_gaps is set) and hold it until taken
    task automatic send_item(input logic [63:0] bits, input logic eoc);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
            @(negedge i_clk);
            start = 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        start          = 1'b1;
        i_sample_bits  = bits;
        i_end_of_chunk = eoc;
        forever begin
            @(posedge i_clk);
            if (!busy) break;
        end
        sb.note_sample(bits, eoc);
        items_sent++;
    endtask

    // Drop start and wait for every due result
    task automatic drain();
        @(negedge i_clk);
        start = 1'b0;
        while (sb.due.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic [63:0] corner_sample(input logic [2:0] fmt);
        logic [63:0] f32c [16] = '{
            64'h0, 64'h8000_0000, 64'h3F80_0000, 64'hBF80_0000, 64'h7F80_0000,
            64'hFF80_0000, 64'h7FC0_0001, 64'hFF81_2345, 64'h1, 64'h007F_FFFF,
            64'h7F7F_FFFF, 64'h4F00_0000, 64'h3F7F_FFFF, 64'hBF80_0001,
            64'h3800_0100, 64'hCF00_0000};
        logic [63:0] f64c [16] = '{
            64'h0, 64'h8000_0000_0000_0000, 64'h3FF0_0000_0000_0000,
            64'hBFF0_0000_0000_0000, 64'h7FF0_0000_0000_0000, 64'hFFF0_0000_0000_0000,
            64'h7FF0_0000_0000_0001, 64'hFFF8_0000_1234_5678, 64'h1,
            64'h47EF_FFFF_E000_0000, 64'h47EF_FFFF_F000_0000, 64'hC7EF_FFFF_EFFF_FFFF,
            64'h36A0_0000_0000_0000, 64'h3690_0000_0000_0000, 64'h3690_0000_0000_0001,
            64'h7FEF_FFFF_FFFF_FFFF};
        logic [63:0] intc [5] = '{
            64'h0, 64'h7FFF_FFFF, 64'h8000_0000, 64'hFFFF_FFFF, 64'h1};
        if (fmt == asfc_pkg::FMT_F32) return f32c[$urandom_range(0, 15)];
        if (fmt == asfc_pkg::FMT_F64) return f64c[$urandom_range(0, 15)];
        case ($urandom_range(0, 4))
            0: return 64'h0;
            1: return {$urandom, $urandom};
            2: return sb.fmt_mask(fmt) >> 1;
            3: return (sb.fmt_mask(fmt) >> 1) + 1;
            default: return intc[$urandom_range(0, 4)];
        endcase
    endfunction

    // Draw a sample: corners, raw noise, or floats of useful or tiny magnitude
    function automatic logic [63:0] draw_sample(input logic [2:0] fmt);
        logic [63:0] r;
        int          pick;
        r    = {$urandom, $urandom};
        pick = $urandom_range(0, 9);
        if (pick <= 2) begin
            r = corner_sample(fmt) | (r & ~sb.fmt_mask(fmt) & {64{$urandom_range(0, 1) == 1}});
        end else if (pick >= 6 && fmt == asfc_pkg::FMT_F32) begin
            r[30:23] = (pick == 9) ? 8'($urandom_range(0, 20)) : 8'($urandom_range(100, 160));
        end else if (pick >= 6 && fmt == asfc_pkg::FMT_F64) begin
            r[62:52] = (pick == 9) ? 11'($urandom_range(860, 910))
                                   : 11'($urandom_range(990, 1060));
            if ($urandom_range(0, 3) == 0) r[28:0] = {1'b1, 28'b0};
        end
        return r;
    endfunction

    initial begin
        logic [2:0] src, tgt;
        int         n;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Reset formats: pcm16 in and out, upper bits ignored
        send_item(64'h0, 1'b0);
        send_item(64'h7FFF, 1'b0);
        send_item(64'h8000, 1'b1);
        send_item(64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
        send_item(64'hA5A5_5A5A_0000_8001, 1'b1);
        drain();

        // Sweep every pair with a target other than pcm8 first, then random pairs with bad codes now and then
        while (items_sent < ITEM_TARGET) begin
            if (phases < 30) begin
                src = 3'(phases / 5);
                tgt = 3'(phases % 5 + 1);
            end else begin
                src = 3'($urandom_range(0, 5));
                tgt = 3'($urandom_range(1, 5));
                if ($urandom_range(0, 15) == 0) src = ($urandom_range(0, 1) == 1) ? FMT_CODE_6
                                                                                   : FMT_CODE_7;
                if ($urandom_range(0, 15) == 0) tgt = ($urandom_range(0, 1) == 1)
                                                      ? asfc_pkg::FMT_PCM8 : FMT_CODE_7;
            end
            if (phases == 30) begin
                src = FMT_CODE_7;
                tgt = asfc_pkg::FMT_PCM8;
            end
            write_reg(asfc_pkg::REG_SOURCE_FORMAT, src);
            write_reg(asfc_pkg::REG_TARGET_FORMAT, tgt);
            no_gaps = ($urandom_range(0, 2) == 0);
            n = $urandom_range(20, 60);
            repeat (n) send_item(draw_sample(src), 1'($urandom_range(0, 7) == 0));
            drain();
            phases++;
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("covered %0d samples over %0d format settings plus the reset setting",
                 items_sent, phases);
        $display("checked %0d results, %0d of them clipped", sb.checked, sb.clipped);
        if (sb.errors == 0 && sb.due.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
